### design/task_scheduler_with_semaphores_defines.svh
// ---------------------------------------------------------------------------
// Task scheduler assertion macros
// Shared property shorthands for the checker files of the task scheduler.
// ---------------------------------------------------------------------------
`ifndef TASK_SCHEDULER_WITH_SEMAPHORES_DEFINES_SVH
`define TASK_SCHEDULER_WITH_SEMAPHORES_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tsched_pkg.sv
// ---------------------------------------------------------------------------
// Task scheduler package
// Command and result types, operation codes and default sizes.
// ---------------------------------------------------------------------------
package tsched_pkg;

  localparam int NUM_TASKS_DEF = 8;
  localparam int NUM_SEMS_DEF  = 4;
  localparam int QUEUE_DEPTH   = 2;

  localparam int TICK_W     = 16;
  localparam int SEM_W      = 8;
  localparam int TASK_IDX_W = 3;
  localparam int SEM_IDX_W  = 2;

  localparam logic signed [SEM_W-1:0] SEM_MIN = -8'sd128;
  localparam logic signed [SEM_W-1:0] SEM_MAX = 8'sd127;

  typedef enum logic [2:0] {
    OP_SCHEDULE = 3'd0,
    OP_WAIT     = 3'd1,
    OP_SIGNAL   = 3'd2,
    OP_SLEEP    = 3'd3,
    OP_LOAD     = 3'd4,
    OP_SET_SEM  = 3'd5,
    OP_NOP      = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAKE,
    ST_SCAN1,
    ST_REFILL,
    ST_SCAN2,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                     op;
    logic [TASK_IDX_W-1:0]   task_index;
    logic [SEM_IDX_W-1:0]    sem_index;
    logic [TICK_W-1:0]       prio;
    logic [TICK_W-1:0]       ticks;
    logic                    sleep_set;
    logic signed [SEM_W-1:0] sem_initial;
  } cmd_t;

  typedef struct packed {
    logic [TASK_IDX_W-1:0] current_task;
    logic                  any_runnable;
    logic                  caller_blocked;
    logic                  woke_task;
    logic [TASK_IDX_W-1:0] woken_index;
  } res_t;

endpackage

### design/task_scheduler_with_semaphores.sv
// ---------------------------------------------------------------------------
// Task scheduler with counting semaphores
// Picks the runnable task with the most remaining ticks and manages FIFO
// waits on counting semaphores.
// ---------------------------------------------------------------------------
// Every input beat gives exactly one result beat. A decode front checks the
// beat and queues it (two entries deep); the back end runs one command at a
// time. Load task, set semaphore, unused codes and a signal that releases no
// one pass from the queue through the execute and done states; a signal that
// releases a waiter also passes the wake state (one ring read). Schedule,
// sleep and a blocking wait run a scan over the task table, one task per
// cycle, with a refill and second pass when the first pass finds no task with
// ticks left. The output register lets the next command run while a result is
// still stalled; its result then waits in the done state. The wait ring RAM is
// not cleared at reset; a signal may read an entry that was never queued.
module task_scheduler_with_semaphores #(
  parameter int NUM_TASKS = tsched_pkg::NUM_TASKS_DEF,
  parameter int NUM_SEMS  = tsched_pkg::NUM_SEMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_opcode,
  input  logic [tsched_pkg::TASK_IDX_W-1:0]   in_task_index,
  input  logic [tsched_pkg::SEM_IDX_W-1:0]    in_sem_index,
  input  logic [tsched_pkg::TICK_W-1:0]       in_task_priority,
  input  logic [tsched_pkg::TICK_W-1:0]       in_task_ticks,
  input  logic [tsched_pkg::TICK_W-1:0]       in_sleep_ticks,
  input  logic signed [tsched_pkg::SEM_W-1:0] in_sem_initial,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tsched_pkg::TASK_IDX_W-1:0]   out_current_task,
  output logic                                out_any_runnable,
  output logic                                out_caller_blocked,
  output logic                                out_woke_task,
  output logic [tsched_pkg::TASK_IDX_W-1:0]   out_woken_index
);
  import tsched_pkg::*;

  logic push, full, pop, empty;
  cmd_t push_cmd, pop_cmd;
  res_t res;

  tsched_front #(
    .NUM_TASKS (NUM_TASKS),
    .NUM_SEMS  (NUM_SEMS)
  ) u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_task_index    (in_task_index),
    .in_sem_index     (in_sem_index),
    .in_task_priority (in_task_priority),
    .in_task_ticks    (in_task_ticks),
    .in_sleep_ticks   (in_sleep_ticks),
    .in_sem_initial   (in_sem_initial),
    .push             (push),
    .push_cmd         (push_cmd),
    .full             (full)
  );

  tsched_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  tsched_back #(
    .NUM_TASKS (NUM_TASKS),
    .NUM_SEMS  (NUM_SEMS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (empty),
    .cmd_in    (pop_cmd),
    .cmd_pop   (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_current_task   = res.current_task;
  assign out_any_runnable   = res.any_runnable;
  assign out_caller_blocked = res.caller_blocked;
  assign out_woke_task      = res.woke_task;
  assign out_woken_index    = res.woken_index;

endmodule

### design/tsched_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tsched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### design/tsched_queue.sv
// ---------------------------------------------------------------------------
// Command queue
// Short FIFO between the decode front and the execution back end.
// ---------------------------------------------------------------------------
module tsched_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tsched_pkg::cmd_t  push_cmd,
  output logic              full,
  input  logic              pop,
  output tsched_pkg::cmd_t  pop_cmd,
  output logic              empty
);
  import tsched_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_next(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_next(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### design/tsched_front.sv
// ---------------------------------------------------------------------------
// Decode front
// Accepts input beats, checks indexes and turns each into a command.
// ---------------------------------------------------------------------------
module tsched_front #(
  parameter int NUM_TASKS = tsched_pkg::NUM_TASKS_DEF,
  parameter int NUM_SEMS  = tsched_pkg::NUM_SEMS_DEF
) (
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [2:0]                                in_opcode,
  input  logic [tsched_pkg::TASK_IDX_W-1:0]         in_task_index,
  input  logic [tsched_pkg::SEM_IDX_W-1:0]          in_sem_index,
  input  logic [tsched_pkg::TICK_W-1:0]             in_task_priority,
  input  logic [tsched_pkg::TICK_W-1:0]             in_task_ticks,
  input  logic [tsched_pkg::TICK_W-1:0]             in_sleep_ticks,
  input  logic signed [tsched_pkg::SEM_W-1:0]       in_sem_initial,
  output logic                                      push,
  output tsched_pkg::cmd_t                          push_cmd,
  input  logic                                      full
);
  import tsched_pkg::*;

  logic task_ok, sem_ok;
  op_t  op_sel;

  assign task_ok = int'(in_task_index) < NUM_TASKS;
  assign sem_ok  = int'(in_sem_index) < NUM_SEMS;

  // Drop out-of-range indexes and unused codes here, so the back end sees a no-op.
  always_comb begin
    case (in_opcode)
      OP_SCHEDULE: op_sel = OP_SCHEDULE;
      OP_WAIT:     op_sel = sem_ok ? OP_WAIT : OP_NOP;
      OP_SIGNAL:   op_sel = sem_ok ? OP_SIGNAL : OP_NOP;
      OP_SLEEP:    op_sel = OP_SLEEP;
      OP_LOAD:     op_sel = task_ok ? OP_LOAD : OP_NOP;
      OP_SET_SEM:  op_sel = sem_ok ? OP_SET_SEM : OP_NOP;
      default:     op_sel = OP_NOP;
    endcase
  end

  always_comb begin
    push_cmd.op          = op_sel;
    push_cmd.task_index  = in_task_index;
    push_cmd.sem_index   = in_sem_index;
    push_cmd.prio        = in_task_priority;
    push_cmd.ticks       = in_task_ticks;
    push_cmd.sleep_set   = |in_sleep_ticks;
    push_cmd.sem_initial = in_sem_initial;
  end

  assign push     = in_valid;
  assign in_stall = full;

endmodule

### design/tsched_back.sv
// ---------------------------------------------------------------------------
// Execution back end
// Holds task and semaphore state, runs commands and the scheduling scan.
// ---------------------------------------------------------------------------
module tsched_back #(
  parameter int NUM_TASKS = tsched_pkg::NUM_TASKS_DEF,
  parameter int NUM_SEMS  = tsched_pkg::NUM_SEMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_empty,
  input  tsched_pkg::cmd_t  cmd_in,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output tsched_pkg::res_t  res
);
  import tsched_pkg::*;

  localparam int TW = $clog2(NUM_TASKS);
  localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int RING_AW    = SW + TW;
  localparam int RING_DEPTH = 2 ** RING_AW;

  // Task state
  logic [TICK_W-1:0]     prio_r  [NUM_TASKS];
  logic [TICK_W-1:0]     ticks_r [NUM_TASKS];
  logic [NUM_TASKS-1:0]  sleep_nz_r, sleep_nz_nxt;
  logic [NUM_TASKS-1:0]  blocked_r, blocked_nxt;
  logic [TW-1:0]         running_r, running_nxt;
  logic [NUM_TASKS-1:0]  runnable;

  // Semaphore state
  logic signed [SEM_W-1:0] sem_count_r [NUM_SEMS];
  logic [TW-1:0]           head_r [NUM_SEMS];
  logic [TW-1:0]           tail_r [NUM_SEMS];

  // Control
  state_t              state_r, state_nxt;
  cmd_t                cmd_r;
  logic [TW-1:0]       idx_r, idx_nxt;
  logic [TICK_W-1:0]   best_r, best_nxt;
  logic [TW-1:0]       pick_r, pick_nxt;
  logic                caller_blocked_r, caller_blocked_nxt;
  logic                woke_r, woke_nxt;
  logic [TW-1:0]       woken_r, woken_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                res_r, res_nxt;

  // Strobes
  logic                    load_we, refill_en, sem_we, head_adv, tail_adv, ring_we;
  logic signed [SEM_W-1:0] sem_wdata;

  // Decoded operands
  logic [TW-1:0]           task_sel;
  logic [SW-1:0]           sem_sel;
  logic signed [SEM_W-1:0] sem_cur, sem_dec, sem_inc;
  logic [TW-1:0]           ring_rdata;

  // Scan step
  logic [TICK_W-1:0] cand_ticks, best_step;
  logic [TW-1:0]     pick_step;
  logic              take, scan_last;

  function automatic logic [TW-1:0] ring_next(input logic [TW-1:0] p);
    logic [TW-1:0] n;
    if (p == TW'(NUM_TASKS - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  assign task_sel = TW'(cmd_r.task_index);
  assign sem_sel  = SW'(cmd_r.sem_index);
  assign sem_cur  = sem_count_r[sem_sel];
  assign sem_dec  = (sem_cur == SEM_MIN) ? sem_cur : sem_cur - 8'sd1;
  assign sem_inc  = (sem_cur == SEM_MAX) ? sem_cur : sem_cur + 8'sd1;
  assign runnable = ~sleep_nz_r & ~blocked_r;

  assign cand_ticks = ticks_r[idx_r];
  assign take       = runnable[idx_r] && (cand_ticks > best_r);
  assign best_step  = take ? cand_ticks : best_r;
  assign pick_step  = take ? idx_r : pick_r;
  assign scan_last  = (idx_r == TW'(NUM_TASKS - 1));

  tsched_ram #(
    .WIDTH (TW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr ({sem_sel, tail_r[sem_sel]}),
    .wdata (running_r),
    .raddr ({sem_sel, head_r[sem_sel]}),
    .rdata (ring_rdata)
  );

  always_comb begin
    state_nxt          = state_r;
    idx_nxt            = idx_r;
    best_nxt           = best_r;
    pick_nxt           = pick_r;
    running_nxt        = running_r;
    caller_blocked_nxt = caller_blocked_r;
    woke_nxt           = woke_r;
    woken_nxt          = woken_r;
    sleep_nz_nxt       = sleep_nz_r;
    blocked_nxt        = blocked_r;
    out_valid_nxt      = out_valid_r && out_stall;
    res_nxt            = res_r;
    cmd_pop            = 1'b0;
    load_we            = 1'b0;
    refill_en          = 1'b0;
    sem_we             = 1'b0;
    sem_wdata          = cmd_r.sem_initial;
    head_adv           = 1'b0;
    tail_adv           = 1'b0;
    ring_we            = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop            = 1'b1;
          caller_blocked_nxt = 1'b0;
          woke_nxt           = 1'b0;
          woken_nxt          = '0;
          state_nxt          = ST_EXEC;
        end
      end

      ST_EXEC: begin
        idx_nxt   = '0;
        best_nxt  = '0;
        pick_nxt  = '0;
        state_nxt = ST_DONE;
        case (cmd_r.op)
          OP_SCHEDULE: begin
            state_nxt = ST_SCAN1;
          end
          OP_WAIT: begin
            sem_we    = 1'b1;
            sem_wdata = sem_dec;
            if (sem_dec[SEM_W-1]) begin
              // block the caller, queue it and pick another task
              blocked_nxt[running_r] = 1'b1;
              ring_we                = 1'b1;
              tail_adv               = 1'b1;
              caller_blocked_nxt     = 1'b1;
              state_nxt              = ST_SCAN1;
            end
          end
          OP_SIGNAL: begin
            sem_we    = 1'b1;
            sem_wdata = sem_inc;
            if (sem_inc[SEM_W-1] || (sem_inc == '0)) begin
              // ring head is read this edge; release it next cycle
              head_adv  = 1'b1;
              woke_nxt  = 1'b1;
              state_nxt = ST_WAKE;
            end
          end
          OP_SLEEP: begin
            sleep_nz_nxt[running_r] = cmd_r.sleep_set;
            state_nxt               = ST_SCAN1;
          end
          OP_LOAD: begin
            load_we                = 1'b1;
            sleep_nz_nxt[task_sel] = cmd_r.sleep_set;
          end
          OP_SET_SEM: begin
            sem_we = 1'b1;
          end
          default: begin
          end
        endcase
      end

      ST_WAKE: begin
        if ({1'b0, ring_rdata} < (TW + 1)'(NUM_TASKS)) begin
          blocked_nxt[ring_rdata] = 1'b0;
        end
        woken_nxt = ring_rdata;
        state_nxt = ST_DONE;
      end

      ST_SCAN1: begin
        idx_nxt  = idx_r + 1'b1;
        best_nxt = best_step;
        pick_nxt = pick_step;
        if (scan_last) begin
          if (best_step != '0) begin
            running_nxt = pick_step;
            state_nxt   = ST_DONE;
          end else begin
            state_nxt = ST_REFILL;
          end
        end
      end

      ST_REFILL: begin
        refill_en = 1'b1;
        idx_nxt   = '0;
        best_nxt  = '0;
        pick_nxt  = '0;
        state_nxt = (|runnable) ? ST_SCAN2 : ST_DONE;
      end

      ST_SCAN2: begin
        idx_nxt  = idx_r + 1'b1;
        best_nxt = best_step;
        pick_nxt = pick_step;
        if (scan_last) begin
          if (best_step != '0) begin
            running_nxt = pick_step;
          end
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          res_nxt.current_task   = TASK_IDX_W'(running_r);
          res_nxt.any_runnable   = |runnable;
          res_nxt.caller_blocked = caller_blocked_r;
          res_nxt.woke_task      = woke_r;
          res_nxt.woken_index    = TASK_IDX_W'(woken_r);
          state_nxt              = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      running_r        <= '0;
      sleep_nz_r       <= '0;
      blocked_r        <= '0;
      caller_blocked_r <= 1'b0;
      woke_r           <= 1'b0;
      woken_r          <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      running_r        <= running_nxt;
      sleep_nz_r       <= sleep_nz_nxt;
      blocked_r        <= blocked_nxt;
      caller_blocked_r <= caller_blocked_nxt;
      woke_r           <= woke_nxt;
      woken_r          <= woken_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    best_r <= best_nxt;
    pick_r <= pick_nxt;
    res_r  <= res_nxt;
    if (cmd_pop) begin
      cmd_r <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < NUM_TASKS; t++) begin
        prio_r[t]  <= '0;
        ticks_r[t] <= '0;
      end
    end else begin
      for (int t = 0; t < NUM_TASKS; t++) begin
        if (load_we && (task_sel == TW'(t))) begin
          prio_r[t]  <= cmd_r.prio;
          ticks_r[t] <= cmd_r.ticks;
        end else if (refill_en && (ticks_r[t] == '0)) begin
          ticks_r[t] <= prio_r[t];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SEMS; s++) begin
        sem_count_r[s] <= '0;
        head_r[s]      <= '0;
        tail_r[s]      <= '0;
      end
    end else begin
      if (sem_we) begin
        sem_count_r[sem_sel] <= sem_wdata;
      end
      if (head_adv) begin
        head_r[sem_sel] <= ring_next(head_r[sem_sel]);
      end
      if (tail_adv) begin
        tail_r[sem_sel] <= ring_next(tail_r[sem_sel]);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

### design/tsched_checker.sv
// ---------------------------------------------------------------------------
// Task scheduler port checker
// Tracks beats in flight at the ports and checks handshake and ordering rules.
// ---------------------------------------------------------------------------
`include "task_scheduler_with_semaphores_defines.svh"

module tsched_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [2:0]                          in_opcode,
  input logic [tsched_pkg::TASK_IDX_W-1:0]   in_task_index,
  input logic [tsched_pkg::SEM_IDX_W-1:0]    in_sem_index,
  input logic [tsched_pkg::TICK_W-1:0]       in_task_priority,
  input logic [tsched_pkg::TICK_W-1:0]       in_task_ticks,
  input logic [tsched_pkg::TICK_W-1:0]       in_sleep_ticks,
  input logic signed [tsched_pkg::SEM_W-1:0] in_sem_initial,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [tsched_pkg::TASK_IDX_W-1:0]   out_current_task,
  input logic                                out_any_runnable,
  input logic                                out_caller_blocked,
  input logic                                out_woke_task,
  input logic [tsched_pkg::TASK_IDX_W-1:0]   out_woken_index
);
  import tsched_pkg::*;

  localparam int IN_PAY_W  = 3 + TASK_IDX_W + SEM_IDX_W + 3 * TICK_W + SEM_W;
  localparam int OUT_PAY_W = 2 * TASK_IDX_W + 3;

  logic                 in_fire, out_fire;
  logic [2:0]           pending_r, pending_nxt;
  logic [IN_PAY_W-1:0]  in_payload;
  logic [OUT_PAY_W-1:0] out_payload;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  assign in_payload  = {in_opcode, in_task_index, in_sem_index, in_task_priority,
                        in_task_ticks, in_sleep_ticks, in_sem_initial};
  assign out_payload = {out_current_task, out_any_runnable, out_caller_blocked,
                        out_woke_task, out_woken_index};

  // Count input beats whose result has not been taken yet.
  always_comb begin
    pending_nxt = pending_r + {2'b00, in_fire} - {2'b00, out_fire};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `TS_ASSERT_SAME(a_no_extra_result, clk, rst_n, out_valid,
                  pending_r != 3'd0, "result without input")
  `TS_ASSERT_SAME(a_in_flight_bound, clk, rst_n, 1'b1,
                  pending_r <= 3'd4, "too many beats in flight")
  `TS_ASSERT_SAME(a_empty_not_stalled, clk, rst_n, pending_r == 3'd0,
                  !in_stall, "stall while empty")
  `TS_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
                  in_valid && $stable(in_payload), "stalled input beat changed")
  `TS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                  out_valid && $stable(out_payload), "stalled result changed")

endmodule

bind task_scheduler_with_semaphores tsched_checker u_checker (.*);

### tb/tb_task_scheduler_with_semaphores.sv
// ---------------------------------------------------------------------------
// Task scheduler with semaphores testbench
// Drives schedule, wait, signal, sleep, load and set commands through the
// valid/stall handshake and checks every result beat against an in-bench
// model of the task tables, semaphore counts and wait rings.
// ---------------------------------------------------------------------------
module tb_task_scheduler_with_semaphores;
  timeunit 1ns;
  timeprecision 1ps;

  import tsched_pkg::*;

  localparam logic [2:0] OP_CODE7 = 3'd7;

  typedef struct packed {
    logic [2:0]              op;
    logic [TASK_IDX_W-1:0]   task_idx;
    logic [SEM_IDX_W-1:0]    sem_idx;
    logic [TICK_W-1:0]       prio;
    logic [TICK_W-1:0]       ticks;
    logic [TICK_W-1:0]       slp_ticks;
    logic signed [SEM_W-1:0] sem_init;
  } sched_cmd_t;

  // Mirror of the scheduler state plus the queue of pending picks.
  class task_table_tracker;
    logic [TICK_W-1:0]       prio_tab    [NUM_TASKS_DEF];
    logic [TICK_W-1:0]       ticks_tab   [NUM_TASKS_DEF];
    logic [TICK_W-1:0]       sleep_tab   [NUM_TASKS_DEF];
    bit                      blocked_tab [NUM_TASKS_DEF];
    logic [TASK_IDX_W-1:0]   running;
    logic signed [SEM_W-1:0] sem_cnt     [NUM_SEMS_DEF];
    logic [TASK_IDX_W-1:0]   ring        [NUM_SEMS_DEF][NUM_TASKS_DEF];
    bit                      ring_filled [NUM_SEMS_DEF][NUM_TASKS_DEF];
    logic [TASK_IDX_W-1:0]   head        [NUM_SEMS_DEF];
    logic [TASK_IDX_W-1:0]   tail        [NUM_SEMS_DEF];
    res_t                    expected_picks[$];
    int                      errors;
    int                      seen;

    function new();
      foreach (prio_tab[t]) begin
        prio_tab[t]    = '0;
        ticks_tab[t]   = '0;
        sleep_tab[t]   = '0;
        blocked_tab[t] = 1'b0;
      end
      foreach (sem_cnt[s]) begin
        sem_cnt[s] = '0;
        head[s]    = '0;
        tail[s]    = '0;
      end
      foreach (ring[s, t]) begin
        ring[s][t]        = '0;
        ring_filled[s][t] = 1'b0;
      end
      running = '0;
      errors  = 0;
      seen    = 0;
    endfunction

    function bit is_ready(int t);
      return sleep_tab[t] == 0 && !blocked_tab[t];
    endfunction

    function int ready_count();
      int n;
      n = 0;
      for (int t = 0; t < NUM_TASKS_DEF; t++) if (is_ready(t)) n++;
      return n;
    endfunction

    function int best_pass();
      int best;
      best = 0;
      for (int t = 0; t < NUM_TASKS_DEF; t++) begin
        if (is_ready(t) && ticks_tab[t] > best) begin
          best    = int'(ticks_tab[t]);
          running = TASK_IDX_W'(t);
        end
      end
      return best;
    endfunction

    // Refill zero-tick tasks once when nothing runnable has ticks left.
    function void pick_next();
      if (best_pass() != 0) return;
      for (int t = 0; t < NUM_TASKS_DEF; t++)
        if (ticks_tab[t] == 0) ticks_tab[t] = prio_tab[t];
      if (ready_count() != 0) void'(best_pass());
    endfunction

    function bit signal_hits_unwritten(int si);
      logic signed [SEM_W-1:0] c;
      c = sem_cnt[si];
      if (c != SEM_MAX) c = c + 8'sd1;
      return (c <= 0) && !ring_filled[si][head[si]];
    endfunction

    function void note_command(sched_cmd_t c);
      res_t                  r;
      logic [TASK_IDX_W-1:0] cur;
      logic [TASK_IDX_W-1:0] w;
      int                    si;
      int                    ti;
      r   = '0;
      cur = running;
      si  = int'(c.sem_idx);
      ti  = int'(c.task_idx);
      case (c.op)
        OP_SCHEDULE: pick_next();
        OP_WAIT: begin
          if (sem_cnt[si] > SEM_MIN) sem_cnt[si] = sem_cnt[si] - 8'sd1;
          if (sem_cnt[si] < 0) begin
            blocked_tab[cur]          = 1'b1;
            ring[si][tail[si]]        = cur;
            ring_filled[si][tail[si]] = 1'b1;
            tail[si]                  = tail[si] + 1'b1;
            r.caller_blocked          = 1'b1;
            pick_next();
          end
        end
        OP_SIGNAL: begin
          if (sem_cnt[si] < SEM_MAX) sem_cnt[si] = sem_cnt[si] + 8'sd1;
          if (sem_cnt[si] <= 0) begin
            w              = ring[si][head[si]];
            blocked_tab[w] = 1'b0;
            head[si]       = head[si] + 1'b1;
            r.woke_task    = 1'b1;
            r.woken_index  = w;
          end
        end
        OP_SLEEP: begin
          sleep_tab[cur] = c.slp_ticks;
          pick_next();
        end
        OP_LOAD: begin
          prio_tab[ti]  = c.prio;
          ticks_tab[ti] = c.ticks;
          sleep_tab[ti] = c.slp_ticks;
        end
        OP_SET_SEM: sem_cnt[si] = c.sem_init;
        default: ;
      endcase
      r.current_task = running;
      r.any_runnable = ready_count() != 0;
      expected_picks.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR: result %0d: %s", seen, msg);
      errors++;
    endtask

    task check_pick(res_t got);
      res_t want;
      seen++;
      if (expected_picks.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = expected_picks.pop_front();
      if (got.current_task !== want.current_task)
        report($sformatf("current_task %0d, want %0d", got.current_task, want.current_task));
      if (got.any_runnable !== want.any_runnable)
        report($sformatf("any_runnable %0d, want %0d", got.any_runnable, want.any_runnable));
      if (got.caller_blocked !== want.caller_blocked)
        report($sformatf("caller_blocked %0d, want %0d", got.caller_blocked,
                         want.caller_blocked));
      if (got.woke_task !== want.woke_task)
        report($sformatf("woke_task %0d, want %0d", got.woke_task, want.woke_task));
      if (got.woken_index !== want.woken_index)
        report($sformatf("woken_index %0d, want %0d", got.woken_index, want.woken_index));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [2:0]              in_opcode = '0;
  logic [TASK_IDX_W-1:0]   in_task_index = '0;
  logic [SEM_IDX_W-1:0]    in_sem_index = '0;
  logic [TICK_W-1:0]       in_task_priority = '0;
  logic [TICK_W-1:0]       in_task_ticks = '0;
  logic [TICK_W-1:0]       in_sleep_ticks = '0;
  logic signed [SEM_W-1:0] in_sem_initial = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [TASK_IDX_W-1:0]   out_current_task;
  logic                    out_any_runnable;
  logic                    out_caller_blocked;
  logic                    out_woke_task;
  logic [TASK_IDX_W-1:0]   out_woken_index;

  int send_idle_pct = 8;
  int recv_idle_pct = 67;

  task_table_tracker sb;

  task_scheduler_with_semaphores i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_task_index      (in_task_index),
    .in_sem_index       (in_sem_index),
    .in_task_priority   (in_task_priority),
    .in_task_ticks      (in_task_ticks),
    .in_sleep_ticks     (in_sleep_ticks),
    .in_sem_initial     (in_sem_initial),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_current_task   (out_current_task),
    .out_any_runnable   (out_any_runnable),
    .out_caller_blocked (out_caller_blocked),
    .out_woke_task      (out_woke_task),
    .out_woken_index    (out_woken_index)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin : watch_results
    res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.current_task   = out_current_task;
      got.any_runnable   = out_any_runnable;
      got.caller_blocked = out_caller_blocked;
      got.woke_task      = out_woke_task;
      got.woken_index    = out_woken_index;
      sb.check_pick(got);
    end
  end

  function automatic sched_cmd_t mk(logic [2:0] op, int ti, int si, int prio, int ticks,
                                    int slp, int init);
    sched_cmd_t c;
    c.op        = op;
    c.task_idx  = TASK_IDX_W'(ti);
    c.sem_idx   = SEM_IDX_W'(si);
    c.prio      = TICK_W'(prio);
    c.ticks     = TICK_W'(ticks);
    c.slp_ticks = TICK_W'(slp);
    c.sem_init  = SEM_W'(init);
    return c;
  endfunction

  function automatic logic [TICK_W-1:0] rand_tick();
    int r;
    r = $urandom_range(99);
    if (r < 60) return TICK_W'($urandom_range(15));
    if (r < 80) return TICK_W'($urandom());
    if (r < 90) return '0;
    return '1;
  endfunction

  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int         r;
    int         v;
    int         neg_sem;
    c.op        = OP_SCHEDULE;
    c.task_idx  = TASK_IDX_W'($urandom_range(NUM_TASKS_DEF - 1));
    c.sem_idx   = SEM_IDX_W'($urandom_range(NUM_SEMS_DEF - 1));
    c.prio      = rand_tick();
    c.ticks     = rand_tick();
    c.slp_ticks = rand_tick();
    v           = int'($urandom_range(135));
    v           = v - 8;
    c.sem_init  = v[SEM_W-1:0];
    neg_sem     = -1;
    for (int s = 0; s < NUM_SEMS_DEF; s++)
      if (sb.sem_cnt[s] < 0 && !sb.signal_hits_unwritten(s)) neg_sem = s;
    // Release waiters when few tasks are left to run.
    if (sb.ready_count() <= 2 && neg_sem >= 0 && $urandom_range(99) < 50) begin
      c.op      = OP_SIGNAL;
      c.sem_idx = SEM_IDX_W'(neg_sem);
      return c;
    end
    r = $urandom_range(99);
    if (r < 22) c.op = OP_SCHEDULE;
    else if (r < 36) begin
      c.op = OP_WAIT;
      if (sb.sem_cnt[c.sem_idx] <= -6) c.op = OP_SIGNAL;
    end
    else if (r < 50) c.op = OP_SIGNAL;
    else if (r < 60) c.op = OP_SLEEP;
    else if (r < 84) begin
      c.op = OP_LOAD;
      if ($urandom_range(3) != 0) c.slp_ticks = '0;
    end
    else if (r < 94) begin
      c.op = OP_SET_SEM;
      if ($urandom_range(4) != 0) c.sem_init = SEM_W'($urandom_range(3));
    end
    else if (r < 97) c.op = $urandom_range(1) ? OP_NOP : OP_CODE7;
    else c.op = 3'($urandom_range(7));
    return c;
  endfunction

  task automatic send_cmd(sched_cmd_t c);
    // Never let a signal release from a ring slot that was never filled.
    if (c.op == OP_SIGNAL && sb.signal_hits_unwritten(int'(c.sem_idx))) c.op = OP_SCHEDULE;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= c.op;
    in_task_index    <= c.task_idx;
    in_sem_index     <= c.sem_idx;
    in_task_priority <= c.prio;
    in_task_ticks    <= c.ticks;
    in_sleep_ticks   <= c.slp_ticks;
    in_sem_initial   <= c.sem_init;
    do @(posedge clk); while (in_stall);
    sb.note_command(c);
  endtask

  task automatic run_random(int n);
    repeat (n) send_cmd(random_cmd());
  endtask

  // Hold the sender until every result is back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_picks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    #500_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // All priorities zero: refill finds nothing, task 0 stays.
    send_cmd(mk(OP_SCHEDULE, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_LOAD, 7, 0, 16'hFFFF, 0, 0, 0));
    send_cmd(mk(OP_LOAD, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0));
    send_cmd(mk(OP_LOAD, 3, 0, 5, 5, 0, 0));
    send_cmd(mk(OP_LOAD, 5, 0, 5, 5, 0, 0));
    // Tie on ticks: lowest index wins.
    send_cmd(mk(OP_SCHEDULE, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_LOAD, 3, 0, 5, 0, 0, 0));
    send_cmd(mk(OP_LOAD, 5, 0, 5, 0, 0, 0));
    // Runnable tasks out of ticks: refill and pick again.
    send_cmd(mk(OP_SCHEDULE, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_SET_SEM, 0, 0, 0, 0, 0, 127));
    send_cmd(mk(OP_SIGNAL, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_SET_SEM, 0, 1, 0, 0, 0, 0));
    send_cmd(mk(OP_WAIT, 0, 1, 0, 0, 0, 0));
    send_cmd(mk(OP_WAIT, 0, 1, 0, 0, 0, 0));
    send_cmd(mk(OP_SIGNAL, 0, 1, 0, 0, 0, 0));
    send_cmd(mk(OP_SIGNAL, 0, 1, 0, 0, 0, 0));
    send_cmd(mk(OP_SET_SEM, 0, 2, 0, 0, 0, -8));
    send_cmd(mk(OP_WAIT, 0, 2, 0, 0, 0, 0));
    send_cmd(mk(OP_SIGNAL, 0, 2, 0, 0, 0, 0));
    send_cmd(mk(OP_SLEEP, 0, 0, 0, 0, 16'hFFFF, 0));
    send_cmd(mk(OP_SLEEP, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_NOP, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_CODE7, 7, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF, -1));
    send_cmd(mk(OP_LOAD, 0, 0, 0, 16'hFFFF, 0, 0));

    run_random(400);
    drain();

    send_idle_pct = 67;
    recv_idle_pct = 8;
    run_random(420);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(280);
    // Drive one count down to saturation and overflow its wait ring.
    send_cmd(mk(OP_SET_SEM, 0, 3, 0, 0, 0, -8));
    repeat (126) send_cmd(mk(OP_WAIT, $urandom_range(7), 3, 0, 0, 0, 0));
    repeat (16) send_cmd(mk(OP_SIGNAL, $urandom_range(7), 3, 0, 0, 0, 0));
    in_valid <= 1'b0;

    while (sb.expected_picks.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/tsched_pkg.sv
design/tsched_ram.sv
design/tsched_queue.sv
design/tsched_front.sv
design/tsched_back.sv
design/task_scheduler_with_semaphores.sv
design/tsched_checker.sv
tb/tb_task_scheduler_with_semaphores.sv
